@@ rtl/chained_scatter_hash_table_assert.svh @@
// Assertion macros for the chained scatter hash table.
// Included by modules that check their own control logic.
`ifndef CHAINED_SCATTER_HASH_TABLE_ASSERT_SVH
`define CHAINED_SCATTER_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define CSHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/csht_pkg.sv @@
// Shared types, codes and the hash pre-mix for the chained scatter hash table.
// No dependencies.
`default_nettype none
package csht_pkg;

    localparam int LOG_NODES_DEF = 8;
    localparam int HASH_BITS     = 32;
    // fold passes: four chunk sums bring any 32-bit mix to at most 2^LOG_NODES
    localparam int HASH_STEPS    = 4;
    localparam int HASH_CNT_W    = $clog2(HASH_STEPS);

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_UPDATED  = 3'd3,
        ST_REJECTED = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_HASH,
        OP_HOME,
        OP_NEXT,
        OP_RD_HOME,
        OP_SAVE_T,
        OP_OTHER,
        OP_WR_UPD,
        OP_WR_NEW_HOME,
        OP_WR_OTHER_LINK,
        OP_WR_FR_T,
        OP_WR_HOME_NEW,
        OP_WR_FR_NEW,
        OP_WR_HOME_T_FR,
        OP_RD_FREE,
        OP_FP_DEC,
        OP_SET_FULL,
        OP_RES
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FHOME,
        S_FCHK,
        S_PHOME,
        S_PCHK,
        S_HASH2,
        S_OCMP,
        S_WR_HT,
        S_OWALK,
        S_WR_FT,
        S_WR_HN,
        S_FREE,
        S_FCHK2,
        S_RES_HIT,
        S_RES_MISS,
        S_RES_NEW,
        S_RES_UPD,
        S_RES_FULL
    } t_state;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic hash_done;
        logic is_insert;
        logic used;
        logic key_match;
        logic link_null;
        logic link_is_home;
        logic other_is_home;
        logic fp_zero;
        logic full;
        logic out_busy;
    } t_stat;

    // k = key + 1, then twice the low half plus the high half, mod 2^32
    function automatic logic [HASH_BITS-1:0] hash_mix(input logic [63:0] key);
        logic [63:0] k;
        begin
            k = key + 64'd1;
            hash_mix = {k[30:0], 1'b0} + k[63:32];
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/csht_if.sv @@
// Handshake channels of the chained scatter hash table.
// Depends on nothing; one interface per direction.
`default_nettype none
interface csht_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] key;
    logic [63:0] value;
    modport source (output valid, command, key, value, input ready);
    modport sink (input valid, command, key, value, output ready);
endinterface

interface csht_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] value_out;
    logic [2:0]  status;
    logic        table_full;
    modport source (output valid, found, value_out, status, table_full, input ready);
    modport sink (input valid, found, value_out, status, table_full, output ready);
endinterface
`default_nettype wire

@@ rtl/csht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module csht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/csht_datapath.sv @@
// Datapath: node store, hash fold unit, free pointer and result register.
// Depends on csht_pkg, csht_if, csht_ram, assert macros; driven by csht_ctrl.
`default_nettype none
`include "chained_scatter_hash_table_assert.svh"
module csht_datapath #(
    parameter int LOG_NODES = csht_pkg::LOG_NODES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire csht_pkg::t_cmd  i_cmd,
    output csht_pkg::t_stat      o_stat,
    input  wire logic            i_command,
    input  wire logic [63:0]     i_key,
    input  wire logic [63:0]     i_value,
    csht_out_if.source           o_out
);
    localparam int NODES = 1 << LOG_NODES;
    localparam int LW    = LOG_NODES + 1;
    localparam int WW    = 128 + 1 + LW;
    localparam logic [LW-1:0] MOD = LW'((NODES - 1) | 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(NODES);
    localparam logic [csht_pkg::HASH_BITS-1:0] FOLD_MASK =
        csht_pkg::HASH_BITS'((1 << LOG_NODES) - 1);

    logic                              r_cmd_ins;
    logic [63:0]                       r_key, r_value;
    logic [63:0]                       r_t_key, r_t_val;
    logic [LW-1:0]                     r_t_link;
    logic [LOG_NODES-1:0]              r_home, r_node, r_fp, r_clr;
    logic                              r_full;
    logic [csht_pkg::HASH_BITS-1:0]    r_h;
    logic [csht_pkg::HASH_CNT_W-1:0]   r_hcnt;
    logic                              r_out_valid, r_found, r_out_full;
    logic [63:0]                       r_vout;
    logic [2:0]                        r_status;

    logic                           we, re;
    logic [LOG_NODES-1:0]           waddr, raddr;
    logic [WW-1:0]                  wdata, rdata;
    logic [63:0]                    rd_key, rd_val;
    logic                           rd_used;
    logic [LW-1:0]                  rd_link, hrem;
    logic [csht_pkg::HASH_BITS-1:0] n_h;

    csht_ram #(.WIDTH(WW), .DEPTH(NODES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign {rd_key, rd_val, rd_used, rd_link} = rdata;

    // 2^LOG_NODES is 1 modulo MOD = NODES - 1: sum the LOG_NODES-bit chunks
    always_comb begin
        n_h = '0;
        for (int i = 0; i < csht_pkg::HASH_BITS; i += LOG_NODES) begin
            n_h = n_h + ((r_h >> i) & FOLD_MASK);
        end
    end

    // after the folds the mix is at most 2^LOG_NODES: one subtract finishes it
    assign hrem = (r_h[LW-1:0] >= MOD) ? r_h[LW-1:0] - MOD : r_h[LW-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = r_home;
        wdata = {r_key, r_value, 1'b1, rd_link};
        re    = 1'b0;
        raddr = r_node;
        case (i_cmd.op)
            csht_pkg::OP_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = {{128{1'b0}}, 1'b0, NULL_LINK};
            end
            csht_pkg::OP_HOME, csht_pkg::OP_OTHER: begin
                re    = 1'b1;
                raddr = hrem[LOG_NODES-1:0];
            end
            csht_pkg::OP_NEXT: begin
                re    = 1'b1;
                raddr = rd_link[LOG_NODES-1:0];
            end
            csht_pkg::OP_RD_HOME: begin
                re    = 1'b1;
                raddr = r_home;
            end
            csht_pkg::OP_RD_FREE: begin
                re    = 1'b1;
                raddr = r_fp;
            end
            csht_pkg::OP_FP_DEC: begin
                re    = 1'b1;
                raddr = r_fp - 1'b1;
            end
            csht_pkg::OP_WR_UPD: begin
                we    = 1'b1;
                waddr = r_node;
                wdata = {rd_key, r_value, 1'b1, rd_link};
            end
            csht_pkg::OP_WR_NEW_HOME: begin
                we = 1'b1;
            end
            csht_pkg::OP_WR_OTHER_LINK: begin
                we    = 1'b1;
                waddr = r_node;
                wdata = {rd_key, rd_val, 1'b1, {1'b0, r_fp}};
            end
            csht_pkg::OP_WR_FR_T: begin
                we    = 1'b1;
                waddr = r_fp;
                wdata = {r_t_key, r_t_val, 1'b1, r_t_link};
            end
            csht_pkg::OP_WR_HOME_NEW: begin
                we    = 1'b1;
                wdata = {r_key, r_value, 1'b1, NULL_LINK};
            end
            csht_pkg::OP_WR_FR_NEW: begin
                we    = 1'b1;
                waddr = r_fp;
                wdata = {r_key, r_value, 1'b1, r_t_link};
            end
            csht_pkg::OP_WR_HOME_T_FR: begin
                we    = 1'b1;
                wdata = {r_t_key, r_t_val, 1'b1, {1'b0, r_fp}};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_fp        <= LOG_NODES'(NODES - 1);
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
            r_hcnt      <= '0;
        end else begin
            if (i_cmd.op == csht_pkg::OP_RES) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                csht_pkg::OP_CLEAR: r_clr <= r_clr + 1'b1;
                csht_pkg::OP_LOAD: begin
                    r_cmd_ins <= i_command;
                    r_key     <= i_key;
                    r_value   <= i_value;
                    r_h       <= csht_pkg::hash_mix(i_key);
                    r_hcnt    <= '0;
                end
                csht_pkg::OP_HASH: begin
                    r_h    <= n_h;
                    r_hcnt <= r_hcnt + 1'b1;
                end
                csht_pkg::OP_HOME: begin
                    r_home <= hrem[LOG_NODES-1:0];
                    r_node <= hrem[LOG_NODES-1:0];
                end
                csht_pkg::OP_OTHER: r_node <= hrem[LOG_NODES-1:0];
                csht_pkg::OP_NEXT:  r_node <= rd_link[LOG_NODES-1:0];
                csht_pkg::OP_SAVE_T: begin
                    r_t_key  <= rd_key;
                    r_t_val  <= rd_val;
                    r_t_link <= rd_link;
                    r_h      <= csht_pkg::hash_mix(rd_key);
                    r_hcnt   <= '0;
                end
                csht_pkg::OP_FP_DEC:   r_fp   <= r_fp - 1'b1;
                csht_pkg::OP_SET_FULL: r_full <= 1'b1;
                csht_pkg::OP_RES: begin
                    r_found     <= (i_cmd.code == csht_pkg::ST_HIT) ||
                                   (i_cmd.code == csht_pkg::ST_UPDATED);
                    r_vout      <= (i_cmd.code == csht_pkg::ST_HIT) ? rd_val : 64'd0;
                    r_status    <= i_cmd.code;
                    r_out_full  <= r_full;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.clear_done    = (r_clr == LOG_NODES'(NODES - 1));
        o_stat.hash_done     = (r_hcnt == csht_pkg::HASH_CNT_W'(csht_pkg::HASH_STEPS - 1));
        o_stat.is_insert     = r_cmd_ins;
        o_stat.used          = rd_used;
        o_stat.key_match     = (rd_key == r_key);
        o_stat.link_null     = rd_link[LOG_NODES];
        o_stat.link_is_home  = (rd_link == {1'b0, r_home});
        o_stat.other_is_home = (hrem == {1'b0, r_home});
        o_stat.fp_zero       = (r_fp == '0);
        o_stat.full          = r_full;
        o_stat.out_busy      = r_out_valid && !o_out.ready;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.found      = r_found;
    assign o_out.value_out  = r_vout;
    assign o_out.status     = r_status;
    assign o_out.table_full = r_out_full;

    `CSHT_ASSERT_NXT(a_full_sticky, r_full, r_full, "full flag dropped")
    `CSHT_ASSERT_IMP(a_res_not_busy, i_cmd.op == csht_pkg::OP_RES,
        !(r_out_valid && !o_out.ready), "result loaded over a waiting item")
    `CSHT_ASSERT_IMP(a_fp_no_wrap, i_cmd.op == csht_pkg::OP_FP_DEC, r_fp != '0,
        "free pointer wrapped")
endmodule
`default_nettype wire

@@ rtl/csht_ctrl.sv @@
// Controller state machine: sequences clear, hash, chain walks, placement and
// free scan. Depends on csht_pkg; drives csht_datapath through t_cmd.
`default_nettype none
module csht_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire csht_pkg::t_stat i_stat,
    output csht_pkg::t_cmd       o_cmd
);
    csht_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csht_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        o_cmd.op   = csht_pkg::OP_NONE;
        o_cmd.code = csht_pkg::ST_HIT;
        case (r_state)
            csht_pkg::S_CLEAR: begin
                o_cmd.op = csht_pkg::OP_CLEAR;
                if (i_stat.clear_done) begin
                    n_state = csht_pkg::S_IDLE;
                end
            end
            csht_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = csht_pkg::OP_LOAD;
                    n_state  = csht_pkg::S_HASH;
                end
            end
            csht_pkg::S_HASH: begin
                o_cmd.op = csht_pkg::OP_HASH;
                if (i_stat.hash_done) begin
                    n_state = csht_pkg::S_FHOME;
                end
            end
            csht_pkg::S_FHOME: begin
                o_cmd.op = csht_pkg::OP_HOME;
                n_state  = csht_pkg::S_FCHK;
            end
            csht_pkg::S_FCHK: begin
                if (i_stat.used && i_stat.key_match) begin
                    if (i_stat.is_insert) begin
                        o_cmd.op = csht_pkg::OP_WR_UPD;
                        n_state  = csht_pkg::S_RES_UPD;
                    end else begin
                        n_state = csht_pkg::S_RES_HIT;
                    end
                end else if (!i_stat.link_null) begin
                    o_cmd.op = csht_pkg::OP_NEXT;
                end else if (!i_stat.is_insert) begin
                    n_state = csht_pkg::S_RES_MISS;
                end else if (i_stat.full) begin
                    n_state = csht_pkg::S_RES_FULL;
                end else begin
                    n_state = csht_pkg::S_PHOME;
                end
            end
            csht_pkg::S_PHOME: begin
                o_cmd.op = csht_pkg::OP_RD_HOME;
                n_state  = csht_pkg::S_PCHK;
            end
            csht_pkg::S_PCHK: begin
                if (!i_stat.used) begin
                    o_cmd.op = csht_pkg::OP_WR_NEW_HOME;
                    n_state  = csht_pkg::S_FREE;
                end else begin
                    o_cmd.op = csht_pkg::OP_SAVE_T;
                    n_state  = csht_pkg::S_HASH2;
                end
            end
            csht_pkg::S_HASH2: begin
                o_cmd.op = csht_pkg::OP_HASH;
                if (i_stat.hash_done) begin
                    n_state = csht_pkg::S_OCMP;
                end
            end
            csht_pkg::S_OCMP: begin
                // resident sits in its own home: chain the new key from the free node
                if (i_stat.other_is_home) begin
                    o_cmd.op = csht_pkg::OP_WR_FR_NEW;
                    n_state  = csht_pkg::S_WR_HT;
                end else begin
                    o_cmd.op = csht_pkg::OP_OTHER;
                    n_state  = csht_pkg::S_OWALK;
                end
            end
            csht_pkg::S_WR_HT: begin
                o_cmd.op = csht_pkg::OP_WR_HOME_T_FR;
                n_state  = csht_pkg::S_FREE;
            end
            csht_pkg::S_OWALK: begin
                // find the predecessor of the displaced node and relink it
                if (i_stat.link_is_home) begin
                    o_cmd.op = csht_pkg::OP_WR_OTHER_LINK;
                    n_state  = csht_pkg::S_WR_FT;
                end else if (i_stat.link_null) begin
                    n_state = csht_pkg::S_WR_FT;
                end else begin
                    o_cmd.op = csht_pkg::OP_NEXT;
                end
            end
            csht_pkg::S_WR_FT: begin
                o_cmd.op = csht_pkg::OP_WR_FR_T;
                n_state  = csht_pkg::S_WR_HN;
            end
            csht_pkg::S_WR_HN: begin
                o_cmd.op = csht_pkg::OP_WR_HOME_NEW;
                n_state  = csht_pkg::S_FREE;
            end
            csht_pkg::S_FREE: begin
                o_cmd.op = csht_pkg::OP_RD_FREE;
                n_state  = csht_pkg::S_FCHK2;
            end
            csht_pkg::S_FCHK2: begin
                if (!i_stat.used) begin
                    n_state = csht_pkg::S_RES_NEW;
                end else if (i_stat.fp_zero) begin
                    o_cmd.op = csht_pkg::OP_SET_FULL;
                    n_state  = csht_pkg::S_RES_NEW;
                end else begin
                    o_cmd.op = csht_pkg::OP_FP_DEC;
                end
            end
            csht_pkg::S_RES_HIT, csht_pkg::S_RES_MISS, csht_pkg::S_RES_NEW,
            csht_pkg::S_RES_UPD, csht_pkg::S_RES_FULL: begin
                case (r_state)
                    csht_pkg::S_RES_HIT:  o_cmd.code = csht_pkg::ST_HIT;
                    csht_pkg::S_RES_MISS: o_cmd.code = csht_pkg::ST_MISS;
                    csht_pkg::S_RES_NEW:  o_cmd.code = csht_pkg::ST_INSERTED;
                    csht_pkg::S_RES_UPD:  o_cmd.code = csht_pkg::ST_UPDATED;
                    default:              o_cmd.code = csht_pkg::ST_REJECTED;
                endcase
                // hold until the output register frees up
                if (!i_stat.out_busy) begin
                    o_cmd.op = csht_pkg::OP_RES;
                    n_state  = csht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csht_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/chained_scatter_hash_table.sv @@
// Chained scatter hash table: 64-bit integer keys, chains kept in the node store.
// Input channel i_in carries command (0 lookup, 1 insert/update), key and value;
// output channel o_out carries one item per input: found, value_out, status,
// table_full. Both are valid/ready; an item moves when both are high.
// After reset the node store is swept once, one node per cycle, with i_in.ready
// low. Items are then handled one at a time. Each item takes a load step, the
// hash fold unit (one chunk sum a cycle), a home read and one read per chain
// node visited, then the result goes into the output register. A new key adds
// a home check and, when the home is taken, a further hash of the resident, a
// predecessor walk and up to 3 writes, then a downward free scan that skips
// used nodes. The node store has one read port: every chain step is one read.
// A result waits in the output register while o_out.ready is low; the next item
// is still accepted and processed, and only its own result stalls behind it.
// Once no free node is left, table_full stays set and new keys are rejected.
// Depends on csht_pkg, csht_if, csht_ram, csht_datapath and csht_ctrl.
`default_nettype none
module chained_scatter_hash_table #(
    parameter int LOG_NODES = csht_pkg::LOG_NODES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    csht_in_if.sink     i_in,
    csht_out_if.source  o_out
);
    csht_pkg::t_cmd  cmd;
    csht_pkg::t_stat stat;
    logic            ready;

    csht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    csht_datapath #(.LOG_NODES(LOG_NODES)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_command (i_in.command),
        .i_key     (i_in.key),
        .i_value   (i_in.value),
        .o_out     (o_out)
    );

    assign i_in.ready = ready;
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for the chained scatter hash table: random and directed lookups and inserts,
// checked against a behavioral node-store model. Depends on the DUT, csht_pkg, csht_if.
`default_nettype none
module testbench;

    localparam int LOGN   = csht_pkg::LOG_NODES_DEF;
    localparam int NNODES = 1 << LOGN;
    localparam int NULLP  = NNODES;
    localparam int HMOD   = (NNODES - 1) | 1;

    typedef struct packed {
        logic              found;
        logic [63:0]       value_out;
        csht_pkg::t_status status;
        logic              table_full;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    int   n_errors;

    csht_in_if  in_ch();
    csht_out_if out_ch();

    chained_scatter_hash_table #(.LOG_NODES(LOGN)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    class hash_scoreboard;
        logic [63:0] nkey [NNODES];
        logic [63:0] nval [NNODES];
        bit          nused[NNODES];
        int          nlink[NNODES];
        int          free_ptr;
        bit          full;
        t_result     pending[$];

        function new();
            for (int i = 0; i < NNODES; i++) begin
                nused[i] = 0;
                nlink[i] = NULLP;
                nkey[i]  = '0;
                nval[i]  = '0;
            end
            free_ptr = NNODES - 1;
            full = 0;
        endfunction

        function int home_slot(logic [63:0] key);
            logic [63:0] k;
            logic [31:0] h;
            k = key + 64'd1;
            h = k[31:0] + k[31:0] + k[63:32];
            return int'(h % HMOD);
        endfunction

        function int locate(logic [63:0] key);
            int n, steps;
            n = home_slot(key);
            steps = 0;
            while (n < NNODES && steps < NNODES) begin
                if (nused[n] && nkey[n] == key) return n;
                n = nlink[n];
                steps++;
            end
            return NULLP;
        endfunction

        function void place(logic [63:0] key, logic [63:0] val);
            int tgt, fr, other, steps, f;
            tgt = home_slot(key);
            if (nused[tgt]) begin
                fr = free_ptr;
                other = home_slot(nkey[tgt]);
                if (other != tgt) begin
                    steps = 0;
                    while (other < NNODES && nlink[other] != tgt && steps < NNODES) begin
                        other = nlink[other];
                        steps++;
                    end
                    if (other < NNODES) nlink[other] = fr;
                    nkey[fr] = nkey[tgt];
                    nval[fr] = nval[tgt];
                    nused[fr] = 1;
                    nlink[fr] = nlink[tgt];
                    nlink[tgt] = NULLP;
                end else begin
                    nlink[fr] = nlink[tgt];
                    nlink[tgt] = fr;
                    tgt = fr;
                end
            end
            nkey[tgt] = key;
            nval[tgt] = val;
            nused[tgt] = 1;
            forever begin
                f = free_ptr;
                if (!nused[f]) return;
                if (f == 0) break;
                free_ptr = f - 1;
            end
            full = 1;
        endfunction

        function void note_input(logic cmd, logic [63:0] key, logic [63:0] val);
            t_result r;
            int pos;
            pos = locate(key);
            r.found = pos < NNODES;
            r.value_out = '0;
            if (!cmd) begin
                if (pos < NNODES) begin
                    r.value_out = nval[pos];
                    r.status = csht_pkg::ST_HIT;
                end else begin
                    r.status = csht_pkg::ST_MISS;
                end
            end else if (pos < NNODES) begin
                nval[pos] = val;
                r.status = csht_pkg::ST_UPDATED;
            end else if (full) begin
                r.status = csht_pkg::ST_REJECTED;
            end else begin
                place(key, val);
                r.status = csht_pkg::ST_INSERTED;
            end
            r.table_full = full;
            pending.push_back(r);
        endfunction

        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report("unexpected item", 64'(got.status), 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got.found !== want.found)
                report("found", 64'(got.found), 64'(want.found));
            if (got.value_out !== want.value_out)
                report("value_out", got.value_out, want.value_out);
            if (got.status !== want.status)
                report("status", 64'(got.status), 64'(want.status));
            if (got.table_full !== want.table_full)
                report("table_full", 64'(got.table_full), 64'(want.table_full));
        endtask
    endclass

    hash_scoreboard table_model;
    logic [63:0] used_keys[$];
    bit   long_stall_req;
    bit   long_stall_done;
    int   burst_left;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Keep a lookup or insert on the input until the block takes it.
    task automatic send_item(input logic cmd, input logic [63:0] key, input logic [63:0] val);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) begin
                in_ch.valid <= 0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid   <= 1;
        in_ch.command <= cmd;
        in_ch.key     <= key;
        in_ch.value   <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        table_model.note_input(cmd, key, val);
    endtask

    // Drop valid and wait for every expected result.
    task automatic drain();
        in_ch.valid <= 0;
        do @(posedge i_clk); while (table_model.pending.size() != 0);
    endtask

    function automatic logic [63:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && used_keys.size() > 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (sel < 8) return 64'($urandom_range(0, 600)) * 64'd255;
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] k;
        logic c;
        n_errors = 0;
        burst_left = 0;
        long_stall_req = 0;
        table_model = new();
        i_rst_n = 0;
        in_ch.valid <= 0;
        in_ch.command <= 0;
        in_ch.key <= '0;
        in_ch.value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: key extremes, wrap of key + 1, colliding homes and moved residents.
        send_item(0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(1, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1);
        send_item(1, 64'h8000_0000_0000_0000, 64'h2);
        send_item(1, 64'h0, 64'h3);
        send_item(1, 64'd255, 64'h4);
        send_item(1, 64'd510, 64'h5);
        send_item(1, 64'd254, 64'h6);
        send_item(1, 64'd253, 64'h7);
        send_item(0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(0, 64'd510, 64'hFFFF);
        send_item(1, 64'd255, 64'hAAAA_5555_AAAA_5555);
        send_item(0, 64'd255, 64'h0);
        send_item(0, 64'h1234, 64'h0);
        send_item(0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0);
        drain();
        foreach (table_model.nused[i]) if (table_model.nused[i])
            used_keys.push_back(table_model.nkey[i]);

        // Long receiver hold-off while items keep coming.
        long_stall_req = 1;
        for (int i = 0; i < 1700; i++) begin
            if (i == 300) drain();
            c = $urandom_range(0, 2) != 0;
            k = pick_key();
            if (c) used_keys.push_back(k);
            send_item(c, k, {$urandom, $urandom});
            if (i == 40) long_stall_req = 0;
        end
        // Fill to the end and hit the rejection path.
        while (!table_model.full) begin
            k = {$urandom, $urandom};
            send_item(1, k, {$urandom, $urandom});
            used_keys.push_back(k);
        end
        for (int i = 0; i < 20; i++)
            send_item(1'($urandom_range(0, 1)), pick_key(), {$urandom, $urandom});
        send_item(1, {$urandom, $urandom}, 64'h9);
        drain();
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && table_model.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Receiver: random stall pattern, plus one long hold-off.
    initial begin
        int phase;
        out_ch.ready <= 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (long_stall_req && !long_stall_done) begin
                out_ch.ready <= 0;
                repeat (400) @(posedge i_clk);
                long_stall_done = 1;
            end
            if ((phase / 200) % 3 == 2) out_ch.ready <= 1;
            else out_ch.ready <= $urandom_range(0, 3) != 0;
        end
    end

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.found = out_ch.found;
            r.value_out = out_ch.value_out;
            r.status = csht_pkg::t_status'(out_ch.status);
            r.table_full = out_ch.table_full;
            table_model.check_result(r);
        end
    end

    initial begin
        #100000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/csht_pkg.sv
rtl/csht_if.sv
rtl/csht_ram.sv
rtl/csht_datapath.sv
rtl/csht_ctrl.sv
rtl/chained_scatter_hash_table.sv
dv/testbench.sv
